>>> rtl/wavetable_voice_mixer_macros.svh
// Assertion macros shared by the checker of the wavetable voice mixer.
// No dependencies; included by the files that assert.
`ifndef WAVETABLE_VOICE_MIXER_MACROS_SVH
`define WAVETABLE_VOICE_MIXER_MACROS_SVH

// property checked on every clock edge outside reset
`define WVM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property that also covers the reset cycles
`define WVM_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/wvm_pkg.sv
// Package for the wavetable voice mixer: command codes, register indexes,
// reset values and the key state struct. No dependencies.
`timescale 1ns / 1ps

package wvm_pkg;

  localparam int NUM_VOICES = 3;
  localparam int PHASE_W    = 16;
  localparam int SAMPLE_W   = 8;
  localparam int KEYS_W     = 12;
  localparam int SCAN_W     = 16;
  localparam int CFG_ADDR_W = 2;
  localparam int TDATA_W    = 24;

  // command codes carried in tuser
  localparam logic [1:0] CMD_SAMPLE = 2'd0;
  localparam logic [1:0] CMD_OUTPUT = 2'd1;
  localparam logic [1:0] CMD_SCAN   = 2'd2;
  localparam logic [1:0] CMD_TABLE  = 2'd3;

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_STEP0 = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_STEP1 = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_STEP2 = 2'd2;

  localparam logic [PHASE_W-1:0] STEP0_RST = 16'd878;
  localparam logic [PHASE_W-1:0] STEP1_RST = 16'd986;
  localparam logic [PHASE_W-1:0] STEP2_RST = 16'd1106;

  typedef struct packed {
    logic [KEYS_W-1:0]     key_mask;  // bit k set when key k is down
    logic [NUM_VOICES-1:0] gate;      // keys 0, 2, 4 gating voices 0..2
  } key_state_t;

endpackage

>>> rtl/wavetable_voice_mixer.sv
// An output tick reads voice 0 on its transfer and voices 1 and 2 in ST_V1 and ST_V2,
// one read at a time on the single table port, then registers its mix in ST_MIX once the
// output is free; input waits until then. Scans, samples and table writes do not stall.
// Reset (rst_n, synchronous, active low): phases, held samples, scanner and
// output valid clear, phase steps load defaults; the table is not cleared.
`timescale 1ns / 1ps

module wavetable_voice_mixer #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [wvm_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [wvm_pkg::PHASE_W-1:0]      cfg_wdata,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [0] serial_bit, [8:1] table_index, [16:9] table_value, [23:17] zero
  input  logic [wvm_pkg::TDATA_W-1:0]      in_tdata,
  // [1:0] cmd
  input  logic [1:0]                       in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [7:0] dac_value, [19:8] key_mask, [23:20] zero
  output logic [wvm_pkg::TDATA_W-1:0]      out_tdata
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int DW = $clog2(TABLE_DEPTH + 1);
  localparam int PW = wvm_pkg::PHASE_W + DW;
  localparam int IW = AW + 8;
  localparam int SW = wvm_pkg::SAMPLE_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_V1   = 2'd1;
  localparam logic [1:0] ST_V2   = 2'd2;
  localparam logic [1:0] ST_MIX  = 2'd3;

  logic [1:0] step_r, step_nxt;
  logic [wvm_pkg::PHASE_W-1:0] phase_r [wvm_pkg::NUM_VOICES];
  logic [wvm_pkg::PHASE_W-1:0] inc_r   [wvm_pkg::NUM_VOICES];
  logic [SW-1:0]               held_r  [wvm_pkg::NUM_VOICES];

  logic        acc, start_out, out_free, mix_done;
  logic        out_valid_r;
  logic [SW-1:0]               dac_r;
  logic [wvm_pkg::KEYS_W-1:0]  mask_r;
  wvm_pkg::key_state_t         keys;

  logic [wvm_pkg::PHASE_W-1:0] rd_phase;
  logic [PW-1:0]               prod;
  logic                        rd_en;
  logic [AW-1:0]               rd_addr;
  logic [SW-1:0]               rd_data;
  logic [IW-1:0]               wr_idx;
  logic                        wr_en;
  logic [SW-1:0]               last_smp;
  logic [SW+1:0]               mix_sum;

  assign acc       = in_tvalid && in_tready;
  assign start_out = acc && (in_tuser == wvm_pkg::CMD_OUTPUT);
  assign out_free  = !out_valid_r || out_tready;
  assign mix_done  = (step_r == ST_MIX) && out_free;
  assign in_tready = (step_r == ST_IDLE) || mix_done;

  always_comb begin
    step_nxt = step_r;
    unique case (step_r)
      ST_IDLE: if (start_out) step_nxt = ST_V1;
      ST_V1:   step_nxt = ST_V2;
      ST_V2:   step_nxt = ST_MIX;
      ST_MIX:  if (out_free) step_nxt = start_out ? ST_V1 : ST_IDLE;
      default: step_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= ST_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

  // table index = (phase * depth) >> 16, one voice per cycle
  always_comb begin
    case (step_r)
      ST_V1:   rd_phase = phase_r[1];
      ST_V2:   rd_phase = phase_r[2];
      default: rd_phase = phase_r[0];
    endcase
  end

  assign prod    = PW'(rd_phase) * PW'(TABLE_DEPTH);
  assign rd_addr = prod[wvm_pkg::PHASE_W+AW-1:wvm_pkg::PHASE_W];
  assign rd_en   = start_out || (step_r == ST_V1) || (step_r == ST_V2);

  assign wr_idx = IW'(in_tdata[8:1]);
  assign wr_en  = acc && (in_tuser == wvm_pkg::CMD_TABLE) && (wr_idx < IW'(TABLE_DEPTH));

  wvm_wave_ram #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW),
    .DW    (SW)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_idx[AW-1:0]),
    .wdata (in_tdata[16:9]),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  wvm_key_scan u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .shift_en   (acc && (in_tuser == wvm_pkg::CMD_SCAN)),
    .serial_bit (in_tdata[0]),
    .keys       (keys)
  );

  // phase steps
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inc_r[0] <= wvm_pkg::STEP0_RST;
      inc_r[1] <= wvm_pkg::STEP1_RST;
      inc_r[2] <= wvm_pkg::STEP2_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        wvm_pkg::CFG_STEP0: inc_r[0] <= cfg_wdata;
        wvm_pkg::CFG_STEP1: inc_r[1] <= cfg_wdata;
        wvm_pkg::CFG_STEP2: inc_r[2] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int v = 0; v < wvm_pkg::NUM_VOICES; v++) begin
        phase_r[v] <= '0;
      end
    end else if (acc && (in_tuser == wvm_pkg::CMD_SAMPLE)) begin
      for (int v = 0; v < wvm_pkg::NUM_VOICES; v++) begin
        phase_r[v] <= phase_r[v] + inc_r[v];
      end
    end
  end

  // held samples: registered read data of voices 0 and 1 lands in ST_V1 and ST_V2, of voice 2 when the mix completes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int v = 0; v < wvm_pkg::NUM_VOICES; v++) begin
        held_r[v] <= '0;
      end
    end else begin
      if ((step_r == ST_V1) && keys.gate[0]) held_r[0] <= rd_data;
      if ((step_r == ST_V2) && keys.gate[1]) held_r[1] <= rd_data;
      if (mix_done && keys.gate[2])          held_r[2] <= rd_data;
    end
  end

  assign last_smp = keys.gate[2] ? rd_data : held_r[2];
  assign mix_sum  = (SW+2)'(held_r[0]) + (SW+2)'(held_r[1]) + (SW+2)'(last_smp);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (mix_done) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mix_done) begin
      dac_r  <= mix_sum[SW+1:2];
      mask_r <= keys.key_mask;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, mask_r, dac_r};

endmodule

>>> rtl/wvm_wave_ram.sv
// Waveform table: simple dual-port synchronous RAM, one write and one
// registered read per cycle. No package dependency.
`timescale 1ns / 1ps

module wvm_wave_ram #(
  parameter int DEPTH = 256,
  parameter int AW    = 8,
  parameter int DW    = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/wvm_key_scan.sv
// Serial key scanner: shifts one bit per scan transfer, MSB first, and
// latches a new key word every sixteen bits. Uses wvm_pkg.
`timescale 1ns / 1ps

module wvm_key_scan (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                shift_en,
  input  logic                serial_bit,
  output wvm_pkg::key_state_t keys
);

  logic [wvm_pkg::SCAN_W-1:0] shift_r, shift_nxt;
  logic [3:0]                 cnt_r;
  logic [wvm_pkg::KEYS_W-1:0] word_r;

  assign shift_nxt = {shift_r[wvm_pkg::SCAN_W-2:0], serial_bit};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r <= '0;
      cnt_r   <= '0;
      word_r  <= '0;
    end else if (shift_en) begin
      cnt_r <= cnt_r + 4'd1;
      if (cnt_r == 4'hf) begin
        word_r  <= shift_nxt[wvm_pkg::KEYS_W-1:0];
        shift_r <= '0;
      end else begin
        shift_r <= shift_nxt;
      end
    end
  end

  // key k sits at bit 11-k of the key word
  always_comb begin
    for (int k = 0; k < wvm_pkg::KEYS_W; k++) begin
      keys.key_mask[k] = word_r[wvm_pkg::KEYS_W-1-k];
    end
    keys.gate = {word_r[7], word_r[9], word_r[11]};
  end

endmodule

>>> rtl/wvm_checker.sv
// Port-level checker for the wavetable voice mixer, bound to the top level.
// Uses the assertion macros header and wvm_pkg.
`timescale 1ns / 1ps
`include "wavetable_voice_mixer_macros.svh"

module wvm_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_tvalid,
  input logic                        in_tready,
  input logic [1:0]                  in_tuser,
  input logic                        out_tvalid,
  input logic                        out_tready,
  input logic [wvm_pkg::TDATA_W-1:0] out_tdata
);

  `WVM_ASSERT(a_out_hold, (out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)), "stalled result changed")
  `WVM_ASSERT(a_dac_range, (out_tvalid |-> out_tdata[7:0] <= 8'd191), "dac value out of range")
  `WVM_ASSERT(a_out_tick_busy, (in_tvalid && in_tready && in_tuser == wvm_pkg::CMD_OUTPUT |=> !in_tready), "no stall after output tick")
  `WVM_ASSERT(a_pad_zero, (out_tvalid |-> out_tdata[23:20] == 4'd0), "result padding not zero")
  `WVM_ASSERT_RST(a_rst_clear, (!rst_n |=> !out_tvalid), "result valid after reset")

endmodule

bind wavetable_voice_mixer wvm_checker u_wvm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

>>> tb/wavetable_voice_mixer_test.sv
// Self-checking bench for wavetable_voice_mixer: drives command transfers, predicts
// every mixed sample and key mask, and checks each result transfer in order.
// Depends on wvm_pkg and the wavetable_voice_mixer RTL only.
`timescale 1ns / 1ps

module wavetable_voice_mixer_test;
  import wvm_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 12;
  localparam int HOLD_CYCLES   = 300;
  localparam int TBL_DEPTH     = 256;
  // index past the end of the register list, must be ignored
  localparam logic [CFG_ADDR_W-1:0] CFG_SPARE = 2'd3;

  typedef struct packed {
    logic [1:0]          cmd;
    logic                serial_bit;
    logic [7:0]          table_index;
    logic [SAMPLE_W-1:0] table_value;
  } voice_cmd_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] dac_value;
    logic [KEYS_W-1:0]   key_mask;
  } mix_result_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [PHASE_W-1:0]    cfg_wdata;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [TDATA_W-1:0]    in_tdata;
  logic [1:0]            in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [TDATA_W-1:0]    out_tdata;

  // predicted block state
  logic [PHASE_W-1:0]  step_m    [NUM_VOICES];
  logic [PHASE_W-1:0]  phase_m   [NUM_VOICES];
  logic [SAMPLE_W-1:0] held_m    [NUM_VOICES];
  logic [SCAN_W-1:0]   scan_m;
  logic [3:0]          scan_cnt_m;
  logic [KEYS_W-1:0]   keys_m;
  logic [SAMPLE_W-1:0] table_m   [TBL_DEPTH];
  bit                  written_m [TBL_DEPTH];

  mix_result_t dac_expected_q[$];
  mix_result_t oldest;

  int mismatches    = 0;
  int transfers_in  = 0;
  int results_seen  = 0;
  int step_settings = 1;
  int cycle_count   = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_req = 0;
  int hold_left = 0;

  wavetable_voice_mixer DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),   // [0] serial_bit, [8:1] table_index, [16:9] table_value
    .in_tuser  (in_tuser),   // [1:0] cmd
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)   // [7:0] dac_value, [19:8] key_mask
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
             dac_expected_q.size());
    $display("wavetable_voice_mixer_test: errors");
    $finish;
  end

  function automatic bit voice_gated(int v);
    // voices are gated by keys 0, 2 and 4; key k sits at bit 11-k
    return keys_m[KEYS_W - 1 - 2 * v];
  endfunction

  task automatic advance_voices(voice_cmd_t it);
    mix_result_t r;
    int unsigned sum;
    case (it.cmd)
      CMD_SAMPLE: begin
        for (int v = 0; v < NUM_VOICES; v++) phase_m[v] = phase_m[v] + step_m[v];
      end
      CMD_OUTPUT: begin
        sum = 0;
        for (int v = 0; v < NUM_VOICES; v++) begin
          if (voice_gated(v)) held_m[v] = table_m[phase_m[v][15:8]];
          sum += 32'(held_m[v]);
        end
        r.dac_value = SAMPLE_W'(sum >> 2);
        for (int k = 0; k < KEYS_W; k++) r.key_mask[k] = keys_m[KEYS_W - 1 - k];
        dac_expected_q.push_back(r);
      end
      CMD_SCAN: begin
        scan_m = {scan_m[SCAN_W-2:0], it.serial_bit};
        scan_cnt_m = scan_cnt_m + 4'd1;
        if (scan_cnt_m == 0) begin
          keys_m = scan_m[KEYS_W-1:0];
          scan_m = '0;
        end
      end
      default: begin
        table_m[it.table_index] = it.table_value;
        written_m[it.table_index] = 1'b1;
      end
    endcase
  endtask

  task automatic report_mismatch(string what, int unsigned want, int unsigned got);
    $display("mismatch on %s: expected 0x%0h, got 0x%0h (cycle %0d)", what, want, got,
             cycle_count);
    mismatches++;
  endtask

  // Called at a falling edge; returns at the falling edge after the transfer, with
  // in_tvalid still high so the next item can follow without a gap.
  task automatic send_item(logic [1:0] cmd, logic b, logic [7:0] idx, logic [7:0] val);
    voice_cmd_t it;
    it = '{cmd: cmd, serial_bit: b, table_index: idx, table_value: val};
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= it.cmd;
    in_tdata  <= {{(TDATA_W - 17){1'b0}}, it.table_value, it.table_index, it.serial_bit};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    advance_voices(it);
    transfers_in++;
    @(negedge clk);
  endtask

  task automatic send_noise(logic [1:0] cmd);
    send_item(cmd, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
              8'($urandom_range(0, 255)));
  endtask

  // table entries a gated voice will read get written first; never read unwritten
  task automatic send_output_tick();
    for (int v = 0; v < NUM_VOICES; v++)
      if (voice_gated(v) && !written_m[phase_m[v][15:8]])
        send_item(CMD_TABLE, 1'($urandom_range(0, 1)), phase_m[v][15:8],
                  8'($urandom_range(0, 255)));
    send_noise(CMD_OUTPUT);
  endtask

  task automatic send_scan_word(logic [SCAN_W-1:0] word);
    // finish any partial word first so this one lands on a word boundary
    while (scan_cnt_m != 0) send_noise(CMD_SCAN);
    for (int i = SCAN_W - 1; i >= 0; i--)
      send_item(CMD_SCAN, word[i], 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (dac_expected_q.size() != 0) @(negedge clk);
    // trailing non-output items may still be in flight
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_write(logic [CFG_ADDR_W-1:0] addr, logic [PHASE_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    @(negedge clk);
    case (addr)
      CFG_STEP0: step_m[0] = data;
      CFG_STEP1: step_m[1] = data;
      CFG_STEP2: step_m[2] = data;
      default: ;
    endcase
  endtask

  task automatic write_steps(logic [PHASE_W-1:0] s0, logic [PHASE_W-1:0] s1,
                             logic [PHASE_W-1:0] s2);
    cfg_write(CFG_STEP0, s0);
    cfg_write(CFG_SPARE, 16'($urandom_range(0, 65535)));
    cfg_write(CFG_STEP1, s1);
    cfg_write(CFG_STEP2, s2);
    cfg_we <= 1'b0;
    step_settings++;
  endtask

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (dac_expected_q.size() == 0) begin
        report_mismatch("unexpected result transfer", 0, 32'(out_tdata));
      end else begin
        oldest = dac_expected_q.pop_front();
        if (out_tdata[7:0] != oldest.dac_value)
          report_mismatch("dac_value", 32'(oldest.dac_value), 32'(out_tdata[7:0]));
        if (out_tdata[19:8] != oldest.key_mask)
          report_mismatch("key_mask", 32'(oldest.key_mask), 32'(out_tdata[19:8]));
        if (out_tdata[TDATA_W-1:20] != '0)
          report_mismatch("tdata padding", 0, 32'(out_tdata[TDATA_W-1:20]));
      end
    end
  end

  task automatic test_directed_items();
    send_output_tick();                       // no keys yet: silence, empty mask
    send_item(CMD_TABLE, 1'b1, 8'h00, 8'hFF);
    send_item(CMD_TABLE, 1'b0, 8'hFF, 8'h00);
    send_noise(CMD_SAMPLE);
    send_scan_word(16'hFFFF);                 // every key down
    send_output_tick();
    repeat (3) send_item(CMD_SCAN, 1'b0, 8'h00, 8'h00);
    send_output_tick();                       // partial word leaves keys alone
  endtask

  task automatic test_random_traffic(int n_items, int send_idle, int recv_stall);
    int stop_at;
    int pick;
    stop_at        = transfers_in + n_items;
    send_idle_pct  = send_idle;
    recv_stall_pct = recv_stall;
    while (transfers_in < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 28)      send_scan_word(16'($urandom_range(0, 65535)));
      else if (pick < 50) repeat ($urandom_range(1, 6)) send_noise(CMD_SAMPLE);
      else if (pick < 82) repeat ($urandom_range(1, 3)) send_output_tick();
      else if (pick < 94) repeat ($urandom_range(1, 4)) send_noise(CMD_TABLE);
      else                repeat ($urandom_range(1, 15)) send_noise(CMD_SCAN);
    end
  endtask

  task automatic test_step_setting(logic [PHASE_W-1:0] s0, logic [PHASE_W-1:0] s1,
                                   logic [PHASE_W-1:0] s2, int n_items, int send_idle,
                                   int recv_stall);
    wait_drained();
    write_steps(s0, s1, s2);
    test_random_traffic(n_items, send_idle, recv_stall);
  endtask

  // long receiver hold while output ticks keep coming: the block must stall its input
  task automatic test_output_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_scan_word(16'h0A80);                 // keys 0, 2 and 4 down
    hold_req = 1'b1;
    repeat (60) begin
      send_noise(CMD_SAMPLE);
      send_output_tick();
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_addr  = '0;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = CMD_SAMPLE;
    step_m    = '{STEP0_RST, STEP1_RST, STEP2_RST};
    phase_m   = '{default: '0};
    held_m    = '{default: '0};
    scan_m    = '0;
    scan_cnt_m = '0;
    keys_m    = '0;
    for (int i = 0; i < TBL_DEPTH; i++) begin
      table_m[i]   = '0;
      written_m[i] = 1'b0;
    end
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed_items();
    test_random_traffic(250, 0, 0);
    test_step_setting(16'hFFFF, 16'hFFFF, 16'hFFFF, 250, 55, 0);
    test_step_setting(16'h0000, 16'h0000, 16'h0000, 100, 0, 55);
    test_step_setting(16'h0001, 16'h8000, 16'($urandom_range(0, 65535)), 200, 0, 55);
    test_step_setting(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                      16'($urandom_range(0, 65535)), 250, 33, 33);
    test_output_backpressure();
    wait_drained();

    $display("covered %0d input transfers and %0d result transfers over %0d step settings,",
             transfers_in, results_seen, step_settings);
    $display("with sender gaps, receiver stalls and one long output hold");
    if (mismatches == 0 && dac_expected_q.size() == 0) begin
      $display("wavetable_voice_mixer_test: clean");
    end else begin
      $display("wavetable_voice_mixer_test: errors");
    end
    $finish;
  end

endmodule
